@@ hdl/ardd_pkg.sv @@
// ============================================================================
// ardd_pkg
// Shared types and constants for the adaptive Rice delta decoder: sequencer
// and bit-phase encodings, register indexes and the result record.
// ============================================================================
`default_nettype none

package ardd_pkg;

    // Fixed field widths of the result record
    localparam int SAMPLE_W = 16;
    localparam int COL_W    = 8;
    localparam int POS_W    = 10;

    // Configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int BSIZE_W     = 11;
    localparam int GCOUNT_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd2;

    localparam logic [BSIZE_W-1:0]  BSIZE_RESET  = 11'd265;
    localparam logic [COL_W-1:0]    NCOL_RESET   = 8'd48;
    localparam logic [GCOUNT_W-1:0] GCOUNT_RESET = 16'd0;

    // Bitstream layout
    localparam int RUN_W     = 5;
    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = 4;
    localparam int K_W       = 3;
    localparam logic [RUN_W-1:0] HDR_LAST  = 5'd15;   // last bit of 16-bit first sample
    localparam logic [RUN_W-1:0] K_LAST    = 5'd2;    // last bit of the 3-bit parameter
    localparam logic [RUN_W-1:0] RUN_LIMIT = 5'd18;   // zeros allowed before error

    typedef enum logic [1:0] {
        PH_HDR,
        PH_K,
        PH_RUN,
        PH_VAL
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_OMEGA,
        ST_CMP,
        ST_REC,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [COL_W-1:0]    column;
        logic [POS_W-1:0]    position;
        logic                err;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/adaptive_rice_delta_decoder.sv @@
// ============================================================================
// adaptive_rice_delta_decoder
// Bit-serial decoder for adaptive Rice coded delta blocks, one compressed
// byte per item, decoded samples tagged with column and position.
// ============================================================================
// Each accepted byte is unpacked LSB first by a small sequencer, one bit per
// clock unless a sample is being completed or the result side stalls. A byte
// is accepted, then up to its 8 bits are decoded (fewer when a block ends or
// the group count is reached), each completed sample passes through omega,
// compare/delta and add/subtract in the reconstruction path, and the byte is
// closed, with any stalls from the result side added. The input is stalled
// until the byte is closed. The last result caused by a byte is marked with
// last_of_run; a zero run of 19 gives one result with error_flag set and the
// block is dropped. Nothing is decoded until group_count is written nonzero.
`default_nettype none

module adaptive_rice_delta_decoder #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_BLOCK   = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [ardd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ardd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // compressed bytes
    input  wire logic                              code_valid,
    output logic                                   code_stall,
    input  wire logic [7:0]                        code_byte,
    // decoded samples
    output logic                                   sample_valid,
    input  wire logic                              sample_stall,
    output logic [ardd_pkg::SAMPLE_W-1:0]          sample,
    output logic [ardd_pkg::COL_W-1:0]             column_index,
    output logic [ardd_pkg::POS_W-1:0]             sample_position,
    output logic                                   last_of_run,
    output logic                                   error_flag
);

    localparam int SB      = SAMPLE_BITS;
    localparam int ACC_W   = SAMPLE_BITS + 1;
    localparam int TEMP_W  = SAMPLE_BITS + 2;
    localparam int BLK_RAW = $clog2(MAX_BLOCK + 1);
    localparam int BLK_W   = (BLK_RAW > ardd_pkg::BSIZE_W) ? BLK_RAW : ardd_pkg::BSIZE_W;
    localparam int RW      = ardd_pkg::RUN_W;

    // configuration registers
    logic [ardd_pkg::BSIZE_W-1:0]  bsize_reg;
    logic [ardd_pkg::COL_W-1:0]    ncol_reg;
    logic [ardd_pkg::GCOUNT_W-1:0] gcount_reg;

    // sequencer and decode state
    ardd_pkg::state_t              state_reg, state_next;
    ardd_pkg::phase_t              phase_reg, phase_next;
    logic [ardd_pkg::K_W-1:0]      rice_reg, rice_next;
    logic [SB-1:0]                 prev_reg, prev_next;
    logic [RW-1:0]                 zrun_reg, zrun_next;
    logic [RW-1:0]                 left_reg, left_next;
    logic [RW-1:0]                 bidx_reg, bidx_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [ardd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [ardd_pkg::COL_W-1:0]    col_reg, col_next;
    logic [ardd_pkg::GCOUNT_W-1:0] gdone_reg, gdone_next;
    logic [ardd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    // payload registers
    logic [7:0]                    byte_reg, byte_next;
    logic [TEMP_W-1:0]             temp_reg, temp_next;
    logic [SB-1:0]                 omega_reg, omega_next;
    logic [TEMP_W-1:0]             delta_reg, delta_next;
    logic                          sub_reg, sub_next;

    // decode signals
    logic                          bit_val;
    logic                          halt;
    logic                          room;
    logic [ACC_W-1:0]              acc_or;
    logic [RW-1:0]                 len_w;
    logic                          hdr_done;
    logic                          k_done;
    logic                          run_err;
    logic                          fin;
    logic                          blocked;
    logic                          last_bit;
    logic [ardd_pkg::POS_W-1:0]    pos_inc;
    logic [BLK_W-1:0]              bs_ext;
    logic [BLK_W-1:0]              eff_m1;
    logic                          done_block;
    logic [ardd_pkg::COL_W-1:0]    nc_eff;
    logic [ardd_pkg::COL_W-1:0]    col_inc;
    logic                          col_wrap;
    logic [SB-1:0]                 rec_val;

    logic                          push;
    logic                          close;
    ardd_pkg::result_t             push_item;

    // ------------------------------------------------------------------
    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg  <= ardd_pkg::BSIZE_RESET;
            ncol_reg   <= ardd_pkg::NCOL_RESET;
            gcount_reg <= ardd_pkg::GCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ardd_pkg::CFG_BLOCK_SIZE:  bsize_reg  <= cfg_data[ardd_pkg::BSIZE_W-1:0];
                ardd_pkg::CFG_NUM_COLUMNS: ncol_reg   <= cfg_data[ardd_pkg::COL_W-1:0];
                ardd_pkg::CFG_GROUP_COUNT: gcount_reg <= cfg_data[ardd_pkg::GCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // decode of the current bit
    assign bit_val  = byte_reg[0];
    assign halt     = gdone_reg >= gcount_reg;
    assign acc_or   = acc_reg | ((bit_val && (bidx_reg < RW'(ACC_W)))
                                 ? (ACC_W'(1) << bidx_reg) : '0);
    assign len_w    = (zrun_reg == '0) ? RW'(rice_reg)
                                       : RW'(rice_reg) + zrun_reg - RW'(1);
    assign hdr_done = (phase_reg == ardd_pkg::PH_HDR) && (bidx_reg == ardd_pkg::HDR_LAST);
    assign k_done   = (phase_reg == ardd_pkg::PH_K) && (bidx_reg == ardd_pkg::K_LAST);
    assign run_err  = (phase_reg == ardd_pkg::PH_RUN) && !bit_val
                      && (zrun_reg == ardd_pkg::RUN_LIMIT);
    assign fin      = ((phase_reg == ardd_pkg::PH_RUN) && bit_val && (len_w == '0))
                      || ((phase_reg == ardd_pkg::PH_VAL) && (left_reg == RW'(1)));
    assign blocked  = (hdr_done || run_err) && !room;
    assign last_bit = (cnt_reg == ardd_pkg::CNT_W'(ardd_pkg::BYTE_BITS - 1));

    // block and column bookkeeping
    assign pos_inc  = pos_reg + 1'b1;
    assign bs_ext   = BLK_W'(bsize_reg);
    assign eff_m1   = ((bs_ext < BLK_W'(2)) ? BLK_W'(2)
                       : (bs_ext > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : bs_ext)
                      - BLK_W'(1);
    assign done_block = BLK_W'(pos_inc) >= eff_m1;
    assign nc_eff   = (ncol_reg == '0) ? ardd_pkg::COL_W'(1) : ncol_reg;
    assign col_inc  = col_reg + 1'b1;
    assign col_wrap = col_inc >= nc_eff;

    assign rec_val  = sub_reg ? (prev_reg - delta_reg[SB-1:0])
                              : (prev_reg + delta_reg[SB-1:0]);

    assign code_stall = (state_reg != ardd_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ardd_pkg::ST_IDLE:
            begin
                if (code_valid)
                    state_next = ardd_pkg::ST_BIT;
            end
            ardd_pkg::ST_BIT:
            begin
                if (halt)
                    state_next = ardd_pkg::ST_FLUSH;
                else if (blocked)
                    state_next = ardd_pkg::ST_BIT;
                else if (fin)
                    state_next = ardd_pkg::ST_OMEGA;
                else if (run_err || last_bit)
                    state_next = ardd_pkg::ST_FLUSH;
            end
            ardd_pkg::ST_OMEGA: state_next = ardd_pkg::ST_CMP;
            ardd_pkg::ST_CMP:   state_next = ardd_pkg::ST_REC;
            ardd_pkg::ST_REC:
            begin
                if (room)
                begin
                    if (done_block || (cnt_reg == ardd_pkg::CNT_W'(ardd_pkg::BYTE_BITS)))
                        state_next = ardd_pkg::ST_FLUSH;
                    else
                        state_next = ardd_pkg::ST_BIT;
                end
            end
            ardd_pkg::ST_FLUSH:
            begin
                if (room)
                    state_next = ardd_pkg::ST_IDLE;
            end
            default: state_next = ardd_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and result requests
    always_comb
    begin
        phase_next = phase_reg;
        rice_next  = rice_reg;
        prev_next  = prev_reg;
        zrun_next  = zrun_reg;
        left_next  = left_reg;
        bidx_next  = bidx_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        col_next   = col_reg;
        gdone_next = gdone_reg;
        cnt_next   = cnt_reg;
        byte_next  = byte_reg;
        temp_next  = temp_reg;
        omega_next = omega_reg;
        delta_next = delta_reg;
        sub_next   = sub_reg;
        push       = 1'b0;
        close      = 1'b0;
        push_item.sample   = ardd_pkg::SAMPLE_W'(prev_reg);
        push_item.column   = col_reg;
        push_item.position = pos_inc;
        push_item.err      = 1'b0;

        case (state_reg)
            ardd_pkg::ST_IDLE:
            begin
                if (code_valid)
                begin
                    byte_next = code_byte;
                    cnt_next  = '0;
                end
            end

            ardd_pkg::ST_BIT:
            begin
                if (!halt && !blocked)
                begin
                    byte_next = byte_reg >> 1;
                    cnt_next  = cnt_reg + 1'b1;
                    case (phase_reg)
                        ardd_pkg::PH_HDR:
                        begin
                            acc_next  = acc_or;
                            bidx_next = bidx_reg + 1'b1;
                            if (hdr_done)
                            begin
                                prev_next = acc_or[SB-1:0];
                                pos_next  = '0;
                                push      = 1'b1;
                                push_item.sample   = ardd_pkg::SAMPLE_W'(acc_or[SB-1:0]);
                                push_item.position = '0;
                                acc_next  = '0;
                                bidx_next = '0;
                                rice_next = '0;
                                phase_next = ardd_pkg::PH_K;
                            end
                        end
                        ardd_pkg::PH_K:
                        begin
                            rice_next = rice_reg
                                        | (ardd_pkg::K_W'(bit_val) << bidx_reg[1:0]);
                            bidx_next = bidx_reg + 1'b1;
                            if (k_done)
                            begin
                                bidx_next  = '0;
                                zrun_next  = '0;
                                acc_next   = '0;
                                phase_next = ardd_pkg::PH_RUN;
                            end
                        end
                        ardd_pkg::PH_RUN:
                        begin
                            if (!bit_val)
                            begin
                                if (run_err)
                                begin
                                    push          = 1'b1;
                                    push_item.err = 1'b1;
                                    // drop the block
                                    col_next   = col_wrap ? '0 : col_inc;
                                    gdone_next = col_wrap ? gdone_reg + 1'b1 : gdone_reg;
                                    phase_next = ardd_pkg::PH_HDR;
                                    bidx_next  = '0;
                                    acc_next   = '0;
                                    zrun_next  = '0;
                                    left_next  = '0;
                                end
                                else
                                    zrun_next = zrun_reg + 1'b1;
                            end
                            else
                            begin
                                acc_next  = '0;
                                bidx_next = '0;
                                if (len_w != '0)
                                begin
                                    left_next  = len_w;
                                    phase_next = ardd_pkg::PH_VAL;
                                end
                            end
                        end
                        ardd_pkg::PH_VAL:
                        begin
                            acc_next  = acc_or;
                            bidx_next = bidx_reg + 1'b1;
                            left_next = left_reg - 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            ardd_pkg::ST_OMEGA:
            begin
                // code value, with its implied leading one when the zero run is nonzero
                if (zrun_reg == '0)
                    temp_next = TEMP_W'(acc_reg);
                else if (len_w >= RW'(ACC_W))
                    temp_next = (TEMP_W'(1) << ACC_W) + TEMP_W'(acc_reg);
                else
                    temp_next = (TEMP_W'(1) << len_w) + TEMP_W'(acc_reg);
                // min(prev, max - prev): top bit picks the nearer rail
                omega_next = prev_reg[SB-1] ? ~prev_reg : prev_reg;
            end

            ardd_pkg::ST_CMP:
            begin
                if (temp_reg <= {1'b0, omega_reg, 1'b0})
                begin
                    delta_next = (temp_reg >> 1) + TEMP_W'(temp_reg[0]);
                    sub_next   = temp_reg[0];
                end
                else
                begin
                    delta_next = temp_reg - TEMP_W'(omega_reg);
                    sub_next   = prev_reg[SB-1];
                end
            end

            ardd_pkg::ST_REC:
            begin
                push_item.sample = ardd_pkg::SAMPLE_W'(rec_val);
                if (room)
                begin
                    push      = 1'b1;
                    prev_next = rec_val;
                    pos_next  = pos_inc;
                    zrun_next = '0;
                    acc_next  = '0;
                    bidx_next = '0;
                    left_next = '0;
                    if (done_block)
                    begin
                        col_next   = col_wrap ? '0 : col_inc;
                        gdone_next = col_wrap ? gdone_reg + 1'b1 : gdone_reg;
                        phase_next = ardd_pkg::PH_HDR;
                    end
                    else
                        phase_next = ardd_pkg::PH_RUN;
                end
            end

            ardd_pkg::ST_FLUSH:
            begin
                close = 1'b1;
            end

            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ardd_pkg::ST_IDLE;
            phase_reg <= ardd_pkg::PH_HDR;
            rice_reg  <= '0;
            prev_reg  <= '0;
            zrun_reg  <= '0;
            left_reg  <= '0;
            bidx_reg  <= '0;
            acc_reg   <= '0;
            pos_reg   <= '0;
            col_reg   <= '0;
            gdone_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rice_reg  <= rice_next;
            prev_reg  <= prev_next;
            zrun_reg  <= zrun_next;
            left_reg  <= left_next;
            bidx_reg  <= bidx_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            gdone_reg <= gdone_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        temp_reg  <= temp_next;
        omega_reg <= omega_next;
        delta_reg <= delta_next;
        sub_reg   <= sub_next;
    end

    // ------------------------------------------------------------------
    ardd_outq u_outq (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .push_item       (push_item),
        .close           (close),
        .room            (room),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .column_index    (column_index),
        .sample_position (sample_position),
        .last_of_run     (last_of_run),
        .error_flag      (error_flag)
    );

endmodule

`default_nettype wire

@@ hdl/ardd_outq.sv @@
// ============================================================================
// ardd_outq
// Result holding stage: one pending item plus the output register. An item
// is only known to be the last of its byte when the byte is closed.
// ============================================================================
`default_nettype none

module ardd_outq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire ardd_pkg::result_t             push_item,
    input  wire logic                          close,
    output logic                               room,
    output logic                               sample_valid,
    input  wire logic                          sample_stall,
    output logic [ardd_pkg::SAMPLE_W-1:0]      sample,
    output logic [ardd_pkg::COL_W-1:0]         column_index,
    output logic [ardd_pkg::POS_W-1:0]         sample_position,
    output logic                               last_of_run,
    output logic                               error_flag
);

    logic              pend_vld_reg;
    ardd_pkg::result_t pend_reg;
    logic              vld_reg;
    ardd_pkg::result_t out_reg;
    logic              last_reg;

    logic out_free;
    logic move;

    assign out_free = !vld_reg || !sample_stall;
    assign room     = !pend_vld_reg || out_free;
    // pending item goes out when displaced by a new one or when the byte closes
    assign move     = pend_vld_reg && out_free && (push || close);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            vld_reg      <= 1'b0;
        end
        else
        begin
            if (push)
                pend_vld_reg <= 1'b1;
            else if (move)
                pend_vld_reg <= 1'b0;

            if (move)
                vld_reg <= 1'b1;
            else if (!sample_stall)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            pend_reg <= push_item;
        if (move)
        begin
            out_reg  <= pend_reg;
            last_reg <= close;
        end
    end

    assign sample_valid    = vld_reg;
    assign sample          = out_reg.sample;
    assign column_index    = out_reg.column;
    assign sample_position = out_reg.position;
    assign error_flag      = out_reg.err;
    assign last_of_run     = last_reg;

endmodule

`default_nettype wire
